// ===== rtl/message_template_insert_parser_assert.svh =====
// Assertion macros used by the message template insert parser top level.
`ifndef MESSAGE_TEMPLATE_INSERT_PARSER_ASSERT_SVH
`define MESSAGE_TEMPLATE_INSERT_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MTIP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtip check failed");

// Next-cycle implication, checked outside reset.
`define MTIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtip check failed");

`endif

// ===== rtl/mtip_pkg.sv =====
// Package for the message template insert parser: token types and character codes.
package mtip_pkg;

    localparam int CHAR_W  = 16;
    localparam int COUNT_W = 7;
    localparam int INDEX_W = 7;

    localparam logic [CHAR_W-1:0] CH_NUL     = 16'h0000;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_BANG    = 16'h0021;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 16'h0025;
    localparam logic [CHAR_W-1:0] CH_DOT     = 16'h002E;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_NINE    = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_QUEST   = 16'h003F;
    localparam logic [CHAR_W-1:0] CH_LOWER_N = 16'h006E;
    localparam logic [CHAR_W-1:0] CH_LOWER_S = 16'h0073;

    typedef enum logic [1:0] {
        KIND_LIT = 2'd0,
        KIND_REF = 2'd1,
        KIND_END = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] value;
        logic              last;
    } tok_t;

    // Tokens caused by one character: the insert token, if any, comes first.
    typedef struct packed {
        logic [1:0] count;
        tok_t       tok0;
        tok_t       tok1;
    } parse_res_t;

endpackage

// ===== rtl/mtip_parser.sv =====
// Escape and insert parser: mode state machine and per-character token decode.
module mtip_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic [mtip_pkg::CHAR_W-1:0]  ch,
    input  logic [mtip_pkg::COUNT_W-1:0] arg_count,
    output mtip_pkg::parse_res_t         res
);
    import mtip_pkg::*;

    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_PCT    = 3'd1,
        MODE_ONE    = 3'd2,
        MODE_DIGITS = 3'd3,
        MODE_BANG   = 3'd4,
        MODE_BANG_S = 3'd5,
        MODE_EMIT   = 3'd6
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [3:0]          first_reg, first_next;
    logic [3:0]          second_reg, second_next;
    logic                has2_reg, has2_next;

    logic                is_digit;
    logic                is_escape;
    logic                reproc;
    logic                ins_valid;
    logic                esc_valid;
    logic [INDEX_W-1:0]  idx;
    tok_t                ins_tok;
    tok_t                plain_tok;
    logic                plain_valid;
    logic [1:0]          n_tok;

    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_escape = (ch == CH_ZERO) || (ch == CH_LOWER_N) || (ch == CH_SPACE) ||
                       (ch == CH_DOT) || (ch == CH_BANG) || (ch == CH_PERCENT);

    // index = first * 10 + second, built from shifts
    assign idx = has2_reg
               ? ((INDEX_W'(first_reg) << 3) + (INDEX_W'(first_reg) << 1) + INDEX_W'(second_reg))
               : INDEX_W'(first_reg);

    always_comb
    begin
        mode_next   = mode_reg;
        first_next  = first_reg;
        second_next = second_reg;
        has2_next   = has2_reg;
        reproc      = 1'b0;
        ins_valid   = 1'b0;
        esc_valid   = 1'b0;

        unique case (mode_reg)
            MODE_PLAIN:
            begin
                reproc = 1'b1;
            end
            MODE_PCT:
            begin
                if (is_escape)
                begin
                    esc_valid = 1'b1;
                    mode_next = MODE_PLAIN;
                end
                else if (is_digit)
                begin
                    first_next  = ch[3:0];
                    second_next = 4'd0;
                    has2_next   = 1'b0;
                    mode_next   = MODE_ONE;
                end
                else
                begin
                    reproc = 1'b1;
                end
            end
            MODE_ONE:
            begin
                if (is_digit)
                begin
                    second_next = ch[3:0];
                    has2_next   = 1'b1;
                    mode_next   = MODE_DIGITS;
                end
                else if (ch == CH_BANG)
                begin
                    mode_next = MODE_BANG;
                end
                else
                begin
                    ins_valid = 1'b1;
                    reproc    = 1'b1;
                end
            end
            MODE_DIGITS:
            begin
                if (ch == CH_BANG)
                begin
                    mode_next = MODE_BANG;
                end
                else
                begin
                    ins_valid = 1'b1;
                    reproc    = 1'b1;
                end
            end
            MODE_BANG:
            begin
                if (ch == CH_LOWER_S)
                    mode_next = MODE_BANG_S;
                else
                    reproc = 1'b1;
            end
            MODE_BANG_S:
            begin
                if (ch == CH_BANG)
                    mode_next = MODE_EMIT;
                else
                    reproc = 1'b1;
            end
            MODE_EMIT:
            begin
                ins_valid = 1'b1;
                reproc    = 1'b1;
            end
            default:
            begin
                reproc = 1'b1;
            end
        endcase

        if (reproc)
            mode_next = (ch == CH_PERCENT) ? MODE_PCT : MODE_PLAIN;
    end

    // token from plain-text handling, or from a one-character escape
    always_comb
    begin
        plain_valid     = 1'b0;
        plain_tok.kind  = KIND_LIT;
        plain_tok.value = ch;
        plain_tok.last  = 1'b1;
        if (esc_valid)
        begin
            plain_valid = 1'b1;
            if (ch == CH_ZERO)
                plain_tok.value = CH_NUL;
            else if (ch == CH_LOWER_N)
                plain_tok.value = CH_NEWLINE;
        end
        else if (reproc && (ch != CH_PERCENT))
        begin
            plain_valid = 1'b1;
            if (ch == CH_NUL)
                plain_tok.kind = KIND_END;
        end
    end

    always_comb
    begin
        ins_tok.last = !plain_valid;
        if (idx <= arg_count)
        begin
            ins_tok.kind  = KIND_REF;
            ins_tok.value = CHAR_W'(idx);
        end
        else
        begin
            ins_tok.kind  = KIND_LIT;
            ins_tok.value = CH_QUEST;
        end
    end

    assign n_tok     = {1'b0, ins_valid} + {1'b0, plain_valid};
    assign res.count = n_tok;
    assign res.tok0  = ins_valid ? ins_tok : plain_tok;
    assign res.tok1  = plain_tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PLAIN;
            first_reg  <= 4'd0;
            second_reg <= 4'd0;
            has2_reg   <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            has2_reg   <= has2_next;
        end
    end

endmodule

// ===== rtl/message_template_insert_parser.sv =====
// Top level of the message template insert parser: input register, parser, token buffer.
//
// Usage:
//   Input channel (in_valid / in_stall / template_char) carries one 16-bit
//   template character per transfer. Output channel (out_valid / out_stall)
//   carries one token per transfer: token_kind, token_value, last_of_run.
//   Config channel (cfg_valid / cfg_ready / arg_count) writes the argument
//   count; cfg_ready is always high. Write it only while the block is idle.
// Path: a taken character is held in the input register, decoded
//   combinationally, and its tokens are registered in the token buffer.
// Throughput: one character per cycle while each character gives at most one
//   token and out_stall stays low. A character that closes an insert and is
//   itself text or a NUL gives two tokens; the next character with tokens waits
//   until the second transfers. The two-entry token buffer at the output sets this.
// Reset: parser returns to plain text, buffers empty, arg_count = 0.
// Stall: with out_stall high the head token holds; once the buffer cannot
//   take the decoded character's tokens, in_stall rises the same cycle.
module message_template_insert_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    // character input
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mtip_pkg::CHAR_W-1:0]  template_char,
    // token output
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   token_kind,
    output logic [mtip_pkg::CHAR_W-1:0]  token_value,
    output logic                         last_of_run,
    // config write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mtip_pkg::COUNT_W-1:0] arg_count
);
    import mtip_pkg::*;
    `include "message_template_insert_parser_assert.svh"

    logic                s1_valid_reg, s1_valid_next;
    logic [CHAR_W-1:0]   char_reg;
    logic [COUNT_W-1:0]  arg_count_reg;

    logic [1:0]          cnt_reg, cnt_next;
    tok_t                slot0_reg, slot0_next;
    tok_t                slot1_reg, slot1_next;

    parse_res_t          res;
    logic                in_fire;
    logic                out_fire;
    logic                buf_free;
    logic                advance;
    logic                load;

    assign cfg_ready = 1'b1;

    // output side
    assign out_valid   = (cnt_reg != 2'd0);
    assign out_fire    = out_valid && !out_stall;
    assign token_kind  = slot0_reg.kind;
    assign token_value = slot0_reg.value;
    assign last_of_run = slot0_reg.last;

    // buffer is empty by the next edge
    assign buf_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_fire);

    // decode stage moves on when its tokens fit (or it has none)
    assign advance  = s1_valid_reg && ((res.count == 2'd0) || buf_free);
    assign load     = advance && (res.count != 2'd0);

    assign in_stall      = s1_valid_reg && !advance;
    assign in_fire       = in_valid && !in_stall;
    assign s1_valid_next = in_fire || (s1_valid_reg && !advance);

    mtip_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ch        (char_reg),
        .arg_count (arg_count_reg),
        .res       (res)
    );

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            cnt_next   = res.count;
            slot0_next = res.tok0;
            slot1_next = res.tok1;
        end
        else if (out_fire)
        begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            cnt_reg       <= 2'd0;
            arg_count_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            cnt_reg      <= cnt_next;
            if (cfg_valid && cfg_ready)
                arg_count_reg <= arg_count;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
            char_reg <= template_char;
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    `MTIP_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg != 2'd3)
    `MTIP_ASSERT_NOW(a_last_matches_cnt, out_valid && !slot0_reg.last, cnt_reg == 2'd2)
    `MTIP_ASSERT_NEXT(a_held_char, s1_valid_reg && in_stall, s1_valid_reg && $stable(char_reg))
    `MTIP_ASSERT_NOW(a_pair_is_insert, load && (res.count == 2'd2), res.tok0.kind == KIND_REF || res.tok0.value == CH_QUEST)

endmodule

// ===== tb/message_template_insert_parser_checker.sv =====
// Token checker for the message template insert parser: predicts tokens and compares them.
`timescale 1ns / 1ps

module message_template_insert_parser_checker
    import mtip_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [CHAR_W-1:0]  template_char,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         token_kind,
    input  logic [CHAR_W-1:0]  token_value,
    input  logic               last_of_run,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [COUNT_W-1:0] arg_count,
    output int                 fail_count,
    output int                 tokens_due,
    output int                 tokens_checked,
    output int                 refs_checked
);

    localparam int MAX_PRINTED = 40;

    typedef enum logic [2:0] {
        PM_TEXT    = 3'd0,
        PM_PERCENT = 3'd1,
        PM_DIGIT1  = 3'd2,
        PM_DIGITS  = 3'd3,
        PM_BANG    = 3'd4,
        PM_BANG_S  = 3'd5,
        PM_PENDING = 3'd6
    } parse_mode_t;

    parse_mode_t        cur_mode;
    logic [3:0]         lead_digit;
    logic [3:0]         next_digit;
    logic               two_digits;
    logic [COUNT_W-1:0] arg_limit;
    tok_t               due_tokens [$];

    task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] got,
                                   input logic [CHAR_W-1:0] want);
        fail_count++;
        // past the cap mismatches are only counted
        if (fail_count <= MAX_PRINTED)
            $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    endtask

    function automatic bit is_digit(input logic [CHAR_W-1:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    task automatic queue_token(input kind_t kind, input logic [CHAR_W-1:0] value);
        tok_t t;
        t.kind  = kind;
        t.value = value;
        t.last  = 1'b0;
        due_tokens.push_back(t);
    endtask

    // One character through the parser; a mode that does not consume the
    // character falls through to the next pass of the loop.
    task automatic parse_char(input logic [CHAR_W-1:0] ch);
        int   size_before;
        bit   settled;
        int   idx;
        tok_t tail;
        size_before = due_tokens.size();
        settled     = 1'b0;
        for (int pass = 0; pass < 8 && !settled; pass++) begin
            case (cur_mode)
                PM_TEXT:
                begin
                    if (ch == CH_NUL)
                        queue_token(KIND_END, CH_NUL);
                    else if (ch == CH_PERCENT)
                        cur_mode = PM_PERCENT;
                    else
                        queue_token(KIND_LIT, ch);
                    settled = 1'b1;
                end
                PM_PERCENT:
                begin
                    if (ch == CH_ZERO || ch == CH_LOWER_N || ch == CH_SPACE ||
                        ch == CH_DOT || ch == CH_BANG || ch == CH_PERCENT)
                    begin
                        if (ch == CH_ZERO)
                            queue_token(KIND_LIT, CH_NUL);
                        else if (ch == CH_LOWER_N)
                            queue_token(KIND_LIT, CH_NEWLINE);
                        else
                            queue_token(KIND_LIT, ch);
                        cur_mode = PM_TEXT;
                        settled  = 1'b1;
                    end
                    else if (is_digit(ch))
                    begin
                        lead_digit = ch[3:0];
                        next_digit = 4'd0;
                        two_digits = 1'b0;
                        cur_mode   = PM_DIGIT1;
                        settled    = 1'b1;
                    end
                    else
                    begin
                        // unknown escape: the percent sign is dropped
                        cur_mode = PM_TEXT;
                    end
                end
                PM_DIGIT1:
                begin
                    if (is_digit(ch))
                    begin
                        next_digit = ch[3:0];
                        two_digits = 1'b1;
                        settled    = 1'b1;
                    end
                    cur_mode = PM_DIGITS;
                end
                PM_DIGITS:
                begin
                    if (ch == CH_BANG)
                    begin
                        cur_mode = PM_BANG;
                        settled  = 1'b1;
                    end
                    else
                        cur_mode = PM_PENDING;
                end
                PM_BANG:
                begin
                    if (ch == CH_LOWER_S)
                    begin
                        cur_mode = PM_BANG_S;
                        settled  = 1'b1;
                    end
                    else
                        cur_mode = PM_TEXT;
                end
                PM_BANG_S:
                begin
                    if (ch == CH_BANG)
                    begin
                        cur_mode = PM_PENDING;
                        settled  = 1'b1;
                    end
                    else
                        cur_mode = PM_TEXT;
                end
                PM_PENDING:
                begin
                    idx = two_digits ? int'(lead_digit) * 10 + int'(next_digit)
                                     : int'(lead_digit);
                    if (idx <= int'(arg_limit))
                        queue_token(KIND_REF, CHAR_W'(idx));
                    else
                        queue_token(KIND_LIT, CH_QUEST);
                    cur_mode = PM_TEXT;
                end
                default:
                    cur_mode = PM_TEXT;
            endcase
        end
        if (due_tokens.size() > size_before)
        begin
            tail      = due_tokens.pop_back();
            tail.last = 1'b1;
            due_tokens.push_back(tail);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        tok_t want;
        if (!rst_n)
        begin
            cur_mode   = PM_TEXT;
            lead_digit = 4'd0;
            next_digit = 4'd0;
            two_digits = 1'b0;
            arg_limit  = '0;
            due_tokens.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_tokens.size() == 0)
                    report_mismatch("token with none due", token_value, CH_NUL);
                else
                begin
                    want = due_tokens.pop_front();
                    tokens_checked++;
                    if (want.kind == KIND_REF)
                        refs_checked++;
                    if (token_kind !== want.kind)
                        report_mismatch("token_kind", CHAR_W'(token_kind), CHAR_W'(want.kind));
                    if (token_value !== want.value)
                        report_mismatch("token_value", token_value, want.value);
                    if (last_of_run !== want.last)
                        report_mismatch("last_of_run", CHAR_W'(last_of_run), CHAR_W'(want.last));
                end
            end
            if (cfg_valid && cfg_ready)
                arg_limit = arg_count;
            if (in_valid && !in_stall)
                parse_char(template_char);
        end
        tokens_due = due_tokens.size();
    end

endmodule

// ===== tb/tb_message_template_insert_parser.sv =====
// Testbench top for the message template insert parser: stimulus, stall patterns, verdict.
`timescale 1ns / 1ps

module tb_message_template_insert_parser;
    import mtip_pkg::*;

    // Receiver hold-off long enough to back the parser up to its input.
    localparam int HOLD_OFF_CYCLES = 64;
    // Cycles to wait after the last token: covers a decode still in flight.
    localparam int DRAIN_TAIL      = 8;
    // Characters per random phase; five phases make roughly 650 in all.
    localparam int PHASE_CHARS     = 130;
    // Worst quiet stretch of a good run: the hold-off plus a long sender
    // gap plus the drain tail and random stall runs; taken ~10x over.
    localparam int QUIET_LIMIT     = 1000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [CHAR_W-1:0]  template_char;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         token_kind;
    logic [CHAR_W-1:0]  token_value;
    logic               last_of_run;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] arg_count;

    int fail_count;
    int tokens_due;
    int tokens_checked;
    int refs_checked;

    int burst_left;
    int chars_sent;
    int cfg_writes;
    int arg_setting;
    int hold_off_asks;
    int quiet_cycles;

    message_template_insert_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .template_char (template_char),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .token_value   (token_value),
        .last_of_run   (last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .arg_count     (arg_count)
    );

    message_template_insert_parser_checker token_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .template_char  (template_char),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .token_kind     (token_kind),
        .token_value    (token_value),
        .last_of_run    (last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .arg_count      (arg_count),
        .fail_count     (fail_count),
        .tokens_due     (tokens_due),
        .tokens_checked (tokens_checked),
        .refs_checked   (refs_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sender side. All tasks start and end on a falling edge; every input
    // changes there, and handshakes are sampled on the rising edge.
    // ------------------------------------------------------------------

    // One character transfer, then the burst/gap bookkeeping. A gap lowers
    // valid; within a burst valid stays high into the next transfer.
    task automatic send_char(input logic [CHAR_W-1:0] ch);
        int gap;
        template_char <= ch;
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
        chars_sent++;
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0
                : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 16 : 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char({8'h00, s[i]});
    endtask

    // Sender pauses until every predicted token has come out, then lets the
    // parser settle; used before each phase's arg_count write and at the end.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tokens_due != 0)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    task automatic write_arg_count(input logic [COUNT_W-1:0] v);
        cfg_valid <= 1'b1;
        arg_count <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid   <= 1'b0;
        arg_setting = int'(v);
        cfg_writes++;
    endtask

    // Any character that the parser treats as plain text: no NUL, no '%'.
    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] ch;
        do
        begin
            if ($urandom_range(0, 2) == 0)
                ch = CHAR_W'($urandom);
            else
                ch = CHAR_W'($urandom_range(32'h21, 32'h7E));
        end while (ch == CH_NUL || ch == CH_PERCENT);
        return ch;
    endfunction

    // The six characters that form an escape after '%'.
    function automatic logic [CHAR_W-1:0] escape_char(input int sel);
        case (sel)
            0:       return CH_ZERO;
            1:       return CH_LOWER_N;
            2:       return CH_SPACE;
            3:       return CH_DOT;
            4:       return CH_BANG;
            default: return CH_PERCENT;
        endcase
    endfunction

    // One random template fragment. Inserts dominate so the suffix states
    // and the pending emission get real traffic; the index is steered at
    // the arg_count boundary. Noise fills in the odd and broken cases.
    task automatic send_fragment();
        int pick;
        int idx;
        int n;
        pick = $urandom_range(0, 15);
        if (pick <= 2)
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_char(plain_char());
        end
        else if (pick <= 4)
        begin
            send_char(CH_PERCENT);
            send_char(escape_char($urandom_range(0, 5)));
        end
        else if (pick <= 11)
        begin
            case ($urandom_range(0, 3))
                0:       idx = arg_setting;
                1:       idx = arg_setting + 1;
                2:       idx = $urandom_range(1, 9);
                default: idx = $urandom_range(1, 99);
            endcase
            if (idx < 1)
                idx = 1;
            if (idx > 99)
                idx = 99;
            send_char(CH_PERCENT);
            if (idx >= 10)
                send_char(CH_ZERO + CHAR_W'(idx / 10));
            send_char(CH_ZERO + CHAR_W'(idx % 10));
            // suffix: none, complete, or broken after '!' or after "!s"
            case ($urandom_range(0, 9))
                5, 6, 7: send_text("!s!");
                8:
                begin
                    send_char(CH_BANG);
                    send_char(plain_char());
                end
                9:
                begin
                    send_text("!s");
                    send_char(plain_char());
                end
                default: ;
            endcase
        end
        else if (pick <= 13)
            send_char(CH_NUL);
        else
        begin
            case ($urandom_range(0, 5))
                0, 1:    send_char(CHAR_W'($urandom));
                2:       send_char(CH_PERCENT);
                // digit code with high bits set: must count as plain text
                3:       send_char(CH_ZERO + CHAR_W'($urandom_range(1, 255) * 256
                                                   + $urandom_range(0, 9)));
                4:       send_char(escape_char($urandom_range(0, 5)));
                default: send_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: the stall style changes with each random-length segment. A request
    // from the stimulus makes it hold stall high for HOLD_OFF_CYCLES,
    // counted here, while the sender keeps offering characters.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int style;
        int seg_left;
        int hold_left;
        int hold_seen;
        bit toggle;
        out_stall = 1'b0;
        style     = 0;
        seg_left  = 0;
        hold_left = 0;
        hold_seen = 0;
        toggle    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_seen != hold_off_asks)
            begin
                hold_seen = hold_off_asks;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    style    = $urandom_range(0, 3);
                    seg_left = $urandom_range(20, 150);
                end
                seg_left--;
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        toggle = !toggle;
                        out_stall <= toggle;
                    end
                endcase
            end
        end
    end

    // Watchdog: too long without any transfer on any channel ends the run.
    always @(posedge clk)
    begin : watchdog
        if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall)
            && !(cfg_valid && cfg_ready))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d tokens still due",
                     QUIET_LIMIT, tokens_due);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed template, then five random phases,
    // each under its own arg_count (both extremes included).
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int settings [5];
        int phase_start;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        template_char = '0;
        cfg_valid     = 1'b0;
        arg_count     = '0;
        burst_left    = 1;
        chars_sent    = 0;
        cfg_writes    = 0;
        arg_setting   = 0;
        hold_off_asks = 0;
        quiet_cycles  = 0;
        settings[0]   = 0;
        settings[1]   = 127;
        settings[2]   = 99;
        settings[3]   = 1;
        settings[4]   = $urandom_range(2, 98);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_arg_count(COUNT_W'(12));
        // all six escapes
        send_text("%0%n% %.%!%%");
        // unknown escape followed by a wide all-ones character
        send_char(CH_PERCENT);
        send_char(16'hFFFF);
        // complete suffix: the reference waits for the next character,
        // which here opens a two-digit insert above the count
        send_text("%12!s!");
        send_text("%99");
        // NUL closes the pending insert: '?' and end of message together
        send_char(CH_NUL);
        // broken suffix drops the insert, the breaking character is text
        send_text("%7!x");
        // NUL straight after '%' still ends the message
        send_char(CH_PERCENT);
        send_char(CH_NUL);

        for (int p = 0; p < 5; p++)
        begin
            wait_drained();
            write_arg_count(COUNT_W'(settings[p]));
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS)
            begin
                // one long receiver hold-off while characters keep coming
                if (p == 1 && hold_off_asks == 0 && chars_sent - phase_start >= 40)
                    hold_off_asks++;
                send_fragment();
            end
        end
        wait_drained();

        $display("covered %0d characters over %0d arg_count settings (0, 99, 127 included)",
                 chars_sent, cfg_writes);
        $display("%0d tokens compared, %0d argument references, one %0d-cycle output hold-off",
                 tokens_checked, refs_checked, HOLD_OFF_CYCLES);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mtip_pkg.sv
rtl/mtip_parser.sv
rtl/message_template_insert_parser.sv
tb/message_template_insert_parser_checker.sv
tb/tb_message_template_insert_parser.sv
